// ----- rtl/gtfr_pkg.sv -----
// Package for the glyph text framebuffer renderer.
// Payload structs, function codes, controller states and geometry constants.
// No dependencies.
`timescale 1ns / 1ps

package gtfr_pkg;

    // Frame geometry
    localparam int PAGE_STRIDE   = 132;
    localparam int COLUMN_OFFSET = 4;
    localparam int ROWS          = 64;
    localparam int COLUMNS       = 128;
    localparam int FONT_BYTES    = 4096;
    localparam int GLYPH_SLOTS   = 128;
    localparam int FRAME_BYTES   = PAGE_STRIDE * (ROWS / 8);
    localparam int FRAME_AW      = $clog2(FRAME_BYTES);
    localparam int FONT_AW       = $clog2(FONT_BYTES);
    localparam int SLOT_AW       = $clog2(GLYPH_SLOTS);

    // Function codes
    localparam logic [2:0] FN_LOAD_FONT  = 3'd0;
    localparam logic [2:0] FN_LOAD_GLYPH = 3'd1;
    localparam logic [2:0] FN_DRAW       = 3'd2;
    localparam logic [2:0] FN_PIXEL      = 3'd3;
    localparam logic [2:0] FN_CLEAR      = 3'd4;
    localparam logic [2:0] FN_READ       = 3'd5;

    // Configuration register indexes
    localparam logic [1:0] CFG_FIRST_CODE   = 2'd0;
    localparam logic [1:0] CFG_LAST_CODE    = 2'd1;
    localparam logic [1:0] CFG_GLYPH_HEIGHT = 2'd2;

    typedef struct packed {
        logic [2:0]  func;
        logic [7:0]  row;
        logic [7:0]  column;
        logic [15:0] code;
        logic        color;
        logic        with_gap;
        logic [11:0] address;
        logic [7:0]  data;
        logic [11:0] glyph_start;
        logic [5:0]  glyph_width;
    } in_item_t;

    typedef struct packed {
        logic [7:0] next_row;
        logic       drawn;
        logic [7:0] read_data;
    } out_item_t;

    // Pixel coordinate source
    typedef enum logic [1:0] {
        SEL_ITEM,
        SEL_GLYPH,
        SEL_GAP
    } pix_sel_t;

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_PX_RD,
        ST_PX_WR,
        ST_LOOKUP,
        ST_CHECK,
        ST_GL_RD,
        ST_GL_WR,
        ST_GAP,
        ST_GP_RD,
        ST_GP_WR,
        ST_CLEAR,
        ST_FR_RD,
        ST_FR_CAP,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic     capture;
        pix_sel_t pix_sel;
        logic     pix_wr;
        logic     fr_item;
        logic     cnt_clr;
        logic     yy_inc;
        logic     xx_inc;
        logic     next_set;
        logic     next_inc;
        logic     rd_load;
        logic     clr_wr;
        logic     out_load;
    } cmd_t;

    typedef struct packed {
        logic with_gap;
        logic loop_ok;
        logic gap_ok;
        logic yy_last;
        logic xx_last;
        logic sweep_last;
        logic out_free;
    } sts_t;

endpackage

// ----- rtl/glyph_text_framebuffer_renderer_top.sv -----
// Glyph text framebuffer renderer: top level joining controller and datapath.
// After reset the whole frame memory is cleared; no transaction is taken
// during that pass (configuration writes are). One transaction is worked at
// a time; each pixel is a read-modify-write of the frame memory. A pixel write
// changes one pixel, a frame read fetches one byte, a clear sweeps every byte,
// loads and unused codes only capture the item, and a character writes its
// w*h glyph pixels, then h gap pixels with the gap flag (w glyph width, h glyph
// height). A finished result waits in an output register while the next
// transaction is accepted. Depends on gtfr_pkg, gtfr_ctrl and gtfr_datapath.
`timescale 1ns / 1ps

module glyph_text_framebuffer_renderer_top (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  gtfr_pkg::in_item_t  in_data,
    output logic                out_valid,
    input  logic                out_stall,
    output gtfr_pkg::out_item_t out_data,
    input  logic                cfg_we,
    input  logic [1:0]          cfg_index,
    input  logic [15:0]         cfg_data
);
    import gtfr_pkg::*;

    cmd_t cmd;
    sts_t sts;

    gtfr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_func  (in_data.func),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    gtfr_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .cmd       (cmd),
        .sts       (sts),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

endmodule

// ----- rtl/gtfr_datapath.sv -----
// Datapath: config registers, item register, frame/font/glyph memories,
// loop counters and result/output registers. Depends on gtfr_pkg.
`timescale 1ns / 1ps

module gtfr_datapath (
    input  logic              clk,
    input  logic              rst_n,
    input  gtfr_pkg::in_item_t in_data,
    input  gtfr_pkg::cmd_t    cmd,
    output gtfr_pkg::sts_t    sts,
    output logic              out_valid,
    input  logic              out_stall,
    output gtfr_pkg::out_item_t out_data,
    input  logic              cfg_we,
    input  logic [1:0]        cfg_index,
    input  logic [15:0]       cfg_data
);
    import gtfr_pkg::*;

    logic [15:0] first_code_reg;
    logic [15:0] last_code_reg;
    logic [6:0]  glyph_height_reg;
    in_item_t    item_reg;

    logic [7:0]  frame_mem [FRAME_BYTES];
    logic [7:0]  font_mem  [FONT_BYTES];
    logic [11:0] goff_mem  [GLYPH_SLOTS];
    logic [5:0]  gw_mem    [GLYPH_SLOTS];

    logic [7:0]  fr_q;
    logic [7:0]  font_q;
    logic [11:0] goff_q;
    logic [5:0]  gw_q;

    logic [5:0]  xx_reg;
    logic [6:0]  yy_reg;
    logic [FRAME_AW-1:0] sweep_reg;

    logic [7:0]  next_reg;
    logic        drawn_reg;
    logic [7:0]  rd_reg;
    logic        out_valid_reg;
    out_item_t   out_reg;

    logic [15:0] slot;
    logic        in_range;
    logic        fit;
    logic [3:0]  bw;
    logic [FONT_AW-1:0] font_addr;
    logic [8:0]  prow;
    logic [8:0]  pcol;
    logic        pcolor;
    logic        px_ok;
    logic [FRAME_AW-1:0] pix_idx;
    logic [FRAME_AW-1:0] fr_raddr;
    logic [FRAME_AW-1:0] fr_waddr;
    logic [7:0]  fr_wdata;
    logic [7:0]  mask;
    logic        fr_we;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_code_reg   <= 16'd32;
            last_code_reg    <= 16'd127;
            glyph_height_reg <= 7'd8;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_FIRST_CODE:   first_code_reg   <= cfg_data;
                CFG_LAST_CODE:    last_code_reg    <= cfg_data;
                CFG_GLYPH_HEIGHT: glyph_height_reg <= cfg_data[6:0];
                default: ;
            endcase
        end
    end

    // Glyph lookup and fit check
    always_comb
    begin
        slot     = item_reg.code - first_code_reg;
        in_range = (item_reg.code >= first_code_reg) && (item_reg.code <= last_code_reg)
                   && (slot < 16'(GLYPH_SLOTS));
        fit      = in_range
                   && ((9'(item_reg.row) + 9'(gw_q)) < 9'(ROWS))
                   && ((9'(item_reg.column) + 9'(glyph_height_reg)) < 9'(COLUMNS));
        bw       = 4'((7'(gw_q) + 7'd7) >> 3);
        font_addr = FONT_AW'(goff_q + 12'(11'(yy_reg) * 11'(bw)) + 12'(xx_reg[5:3]));
    end

    // Pixel coordinates
    always_comb
    begin
        case (cmd.pix_sel)
            SEL_GLYPH:
            begin
                prow   = 9'(item_reg.row) + 9'(xx_reg);
                pcol   = 9'(item_reg.column) + 9'(yy_reg);
                pcolor = font_q[3'd7 - xx_reg[2:0]];
            end
            SEL_GAP:
            begin
                prow   = 9'(next_reg);
                pcol   = 9'(item_reg.column) + 9'(yy_reg);
                pcolor = 1'b0;
            end
            default:
            begin
                prow   = 9'(item_reg.row);
                pcol   = 9'(item_reg.column);
                pcolor = item_reg.color;
            end
        endcase
        px_ok    = (prow < 9'(ROWS)) && (pcol < 9'(COLUMNS));
        pix_idx  = FRAME_AW'(prow[5:3]) * FRAME_AW'(PAGE_STRIDE)
                   + FRAME_AW'(pcol[6:0]) + FRAME_AW'(COLUMN_OFFSET);
        mask     = 8'd1 << prow[2:0];
        fr_raddr = cmd.fr_item ? item_reg.address[FRAME_AW-1:0] : pix_idx;
        fr_we    = (cmd.pix_wr && px_ok) || cmd.clr_wr;
        fr_waddr = cmd.clr_wr ? sweep_reg : pix_idx;
        if (cmd.clr_wr)
            fr_wdata = 8'd0;
        else if (pcolor)
            fr_wdata = fr_q | mask;
        else
            fr_wdata = fr_q & ~mask;
    end

    // Frame memory
    always_ff @(posedge clk)
    begin
        if (fr_we)
            frame_mem[fr_waddr] <= fr_wdata;
        fr_q <= frame_mem[fr_raddr];
    end

    // Font store
    always_ff @(posedge clk)
    begin
        if (cmd.capture && in_data.func == FN_LOAD_FONT)
            font_mem[in_data.address[FONT_AW-1:0]] <= in_data.data;
        font_q <= font_mem[font_addr];
    end

    // Glyph table
    always_ff @(posedge clk)
    begin
        if (cmd.capture && in_data.func == FN_LOAD_GLYPH
            && in_data.address < 12'(GLYPH_SLOTS))
        begin
            goff_mem[in_data.address[SLOT_AW-1:0]] <= in_data.glyph_start;
            gw_mem[in_data.address[SLOT_AW-1:0]]   <= in_data.glyph_width;
        end
        goff_q <= goff_mem[slot[SLOT_AW-1:0]];
        gw_q   <= gw_mem[slot[SLOT_AW-1:0]];
    end

    // Item register
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
            item_reg <= in_data;
    end

    // Loop counters and clear sweep
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            xx_reg    <= '0;
            yy_reg    <= '0;
            sweep_reg <= '0;
        end
        else
        begin
            if (cmd.cnt_clr)
            begin
                xx_reg <= '0;
                yy_reg <= '0;
            end
            else if (cmd.xx_inc)
            begin
                xx_reg <= xx_reg + 6'd1;
                yy_reg <= '0;
            end
            else if (cmd.yy_inc)
                yy_reg <= yy_reg + 7'd1;
            if (cmd.clr_wr)
                sweep_reg <= sts.sweep_last ? '0 : sweep_reg + FRAME_AW'(1);
        end
    end

    // Result fields
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            next_reg  <= '0;
            drawn_reg <= 1'b0;
            rd_reg    <= '0;
        end
        else
        begin
            if (cmd.next_set)
            begin
                next_reg  <= fit ? item_reg.row + 8'(gw_q) : item_reg.row;
                drawn_reg <= fit;
            end
            else if (cmd.next_inc)
                next_reg <= next_reg + 8'd1;
            if (cmd.rd_load)
                rd_reg <= (item_reg.address < 12'(FRAME_BYTES)) ? fr_q : 8'd0;
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.out_load)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
            out_reg <= '{next_row: next_reg, drawn: drawn_reg, read_data: rd_reg};
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // Status to controller
    always_comb
    begin
        sts.with_gap   = item_reg.with_gap;
        sts.loop_ok    = fit && (gw_q != 6'd0) && (glyph_height_reg != 7'd0);
        sts.gap_ok     = glyph_height_reg != 7'd0;
        sts.yy_last    = yy_reg == glyph_height_reg - 7'd1;
        sts.xx_last    = xx_reg == gw_q - 6'd1;
        sts.sweep_last = sweep_reg == FRAME_AW'(FRAME_BYTES - 1);
        sts.out_free   = !out_valid_reg || !out_stall;
    end

    a_glyph_on_screen: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.pix_wr && cmd.pix_sel == SEL_GLYPH) |-> px_ok)
        else $error("glyph pixel outside the screen");
    a_sweep_bound: assert property (@(posedge clk) disable iff (!rst_n)
        sweep_reg < FRAME_AW'(FRAME_BYTES))
        else $error("clear sweep out of range");
    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> sts.out_free)
        else $error("output register overwritten");
    a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |=> out_valid_reg)
        else $error("loaded result not presented");

endmodule

// ----- rtl/gtfr_ctrl.sv -----
// Controller state machine: sequences item capture, pixel read-modify-write
// loops, frame clearing and result hand-off. Depends on gtfr_pkg.
`timescale 1ns / 1ps

module gtfr_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    input  logic [2:0]     in_func,
    output logic           in_stall,
    input  gtfr_pkg::sts_t sts,
    output gtfr_pkg::cmd_t cmd
);
    import gtfr_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_INIT;
        else
            state_reg <= state_next;
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_INIT:   if (sts.sweep_last) state_next = ST_IDLE;
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    case (in_func)
                        FN_DRAW:  state_next = ST_LOOKUP;
                        FN_PIXEL: state_next = ST_PX_RD;
                        FN_CLEAR: state_next = ST_CLEAR;
                        FN_READ:  state_next = ST_FR_RD;
                        default:  state_next = ST_DONE;
                    endcase
                end
            end
            ST_PX_RD:  state_next = ST_PX_WR;
            ST_PX_WR:  state_next = ST_DONE;
            ST_LOOKUP: state_next = ST_CHECK;
            ST_CHECK:  state_next = sts.loop_ok ? ST_GL_RD : ST_GAP;
            ST_GL_RD:  state_next = ST_GL_WR;
            ST_GL_WR:  state_next = (sts.yy_last && sts.xx_last) ? ST_GAP : ST_GL_RD;
            ST_GAP:    state_next = (sts.with_gap && sts.gap_ok) ? ST_GP_RD : ST_DONE;
            ST_GP_RD:  state_next = ST_GP_WR;
            ST_GP_WR:  state_next = sts.yy_last ? ST_DONE : ST_GP_RD;
            ST_CLEAR:  if (sts.sweep_last) state_next = ST_DONE;
            ST_FR_RD:  state_next = ST_FR_CAP;
            ST_FR_CAP: state_next = ST_DONE;
            ST_DONE:   if (sts.out_free) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // Outputs
    always_comb
    begin
        cmd      = '0;
        cmd.pix_sel = SEL_ITEM;
        in_stall = 1'b1;
        case (state_reg)
            ST_INIT:   cmd.clr_wr = 1'b1;
            ST_IDLE:
            begin
                in_stall    = 1'b0;
                cmd.capture = in_valid;
            end
            ST_PX_WR:  cmd.pix_wr = 1'b1;
            ST_CHECK:
            begin
                cmd.next_set = 1'b1;
                cmd.cnt_clr  = 1'b1;
            end
            ST_GL_RD:  cmd.pix_sel = SEL_GLYPH;
            ST_GL_WR:
            begin
                cmd.pix_sel = SEL_GLYPH;
                cmd.pix_wr  = 1'b1;
                if (sts.yy_last && sts.xx_last)
                    cmd.cnt_clr = 1'b1;
                else if (sts.yy_last)
                    cmd.xx_inc = 1'b1;
                else
                    cmd.yy_inc = 1'b1;
            end
            ST_GAP:
            begin
                cmd.cnt_clr  = 1'b1;
                cmd.next_inc = sts.with_gap && !sts.gap_ok;
            end
            ST_GP_RD:  cmd.pix_sel = SEL_GAP;
            ST_GP_WR:
            begin
                cmd.pix_sel  = SEL_GAP;
                cmd.pix_wr   = 1'b1;
                cmd.yy_inc   = !sts.yy_last;
                cmd.next_inc = sts.yy_last;
            end
            ST_CLEAR:  cmd.clr_wr = 1'b1;
            ST_FR_RD:  cmd.fr_item = 1'b1;
            ST_FR_CAP: cmd.rd_load = 1'b1;
            ST_DONE:   cmd.out_load = sts.out_free;
            default: ;
        endcase
    end

    a_idle_only_capture: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.capture |-> (state_reg == ST_IDLE && in_valid))
        else $error("capture outside idle");
    a_no_clear_write_mix: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.clr_wr && cmd.pix_wr))
        else $error("clear and pixel write together");
    a_done_leaves: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |=> state_reg == ST_IDLE)
        else $error("controller stuck after result");

endmodule
